FILE: sv/lcl_pkg.sv
// Shared types, constants and character helpers for the line command lock controller.
// Used by lcl_ctrl, lcl_datapath and line_command_lock_controller; no dependencies.
`default_nettype none
package lcl_pkg;

	localparam int LINE_CHARS = 80;
	localparam int IDX_W = $clog2(LINE_CHARS);
	localparam int CNT_W = $clog2(LINE_CHARS + 1);
	localparam int TICK_W = 32;
	localparam int CFG_IDX_W = 1;

	localparam logic [TICK_W-1:0] PULSE_TICKS_RST = 32'd200000000;
	localparam logic [TICK_W-1:0] COOLDOWN_TICKS_RST = 32'd80000000;

	localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN_TICKS = 1'd1;

	localparam logic [7:0] CH_BS = 8'd8;
	localparam logic [7:0] CH_CR = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_DEL = 8'd127;

	localparam logic [CNT_W-1:0] OPEN_LEN = CNT_W'(4);
	localparam logic [CNT_W-1:0] CLOSE_LEN = CNT_W'(5);

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_KICK = 2'd2
	} lcl_op_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic scan_init;
		logic step;
		logic finish;
	} lcl_cmd_t;

	typedef struct packed {
		logic eol;
		logic at_end;
		logic tok_end;
	} lcl_stat_t;

	typedef struct packed {
		logic report_kick;
		logic report_locked;
		logic report_unlocked;
		logic close_drive;
		logic open_drive;
	} lcl_res_t;

	function automatic logic [7:0] word_open_char(input logic [1:0] k);
		logic [7:0] c;
		case (k)
			2'd0: c = 8'h6f;
			2'd1: c = 8'h70;
			2'd2: c = 8'h65;
			default: c = 8'h6e;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] word_close_char(input logic [2:0] k);
		logic [7:0] c;
		case (k)
			3'd0: c = 8'h63;
			3'd1: c = 8'h6c;
			3'd2: c = 8'h6f;
			3'd3: c = 8'h73;
			default: c = 8'h65;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: sv/lcl_ctrl.sv
// Sequencing state machine for the line command lock controller.
// Depends on lcl_pkg; drives lcl_datapath through a command struct.
`default_nettype none
module lcl_ctrl
	import lcl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_fire,
	input  wire lcl_stat_t stat,
	output lcl_cmd_t       cmd,
	output logic           idle
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_CHK  = 4'b0100,
		ST_EV   = 4'b1000
	} lcl_state_t;

	lcl_state_t state_q;
	lcl_state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.eol) begin
					cmd.scan_init = 1'b1;
					state_d = ST_CHK;
				end else begin
					cmd.exec = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_CHK: begin
				if (stat.at_end) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end else begin
					state_d = ST_EV;
				end
			end
			ST_EV: begin
				if (stat.tok_end) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d = ST_CHK;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign idle = (state_q == ST_IDLE);

endmodule
`default_nettype wire

FILE: sv/lcl_datapath.sv
// Line store, token scanner, pulse and cooldown timers of the lock controller.
// Depends on lcl_pkg; commanded by lcl_ctrl.
`default_nettype none
module lcl_datapath
	import lcl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lcl_cmd_t             cmd,
	input  wire logic [1:0]           in_op,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_data,
	output lcl_stat_t                 stat,
	output lcl_res_t                  res
);

	logic [7:0] line_mem [LINE_CHARS];
	logic [7:0] rd_data_q;

	logic [1:0]        op_q;
	logic [7:0]        byte_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  k_q, k_d;
	logic              in_tok_q, in_tok_d;
	logic              m_open_q, m_open_d;
	logic              m_close_q, m_close_d;
	logic              open_q, open_d;
	logic              close_q, close_d;
	logic              run_q, run_d;
	logic [TICK_W-1:0] pulse_el_q, pulse_el_d;
	logic              armed_q, armed_d;
	logic [TICK_W-1:0] cool_el_q, cool_el_d;
	logic [TICK_W-1:0] pulse_ticks_q;
	logic [TICK_W-1:0] cool_ticks_q;
	logic              mem_we;
	logic [TICK_W-1:0] pulse_inc;
	logic [TICK_W-1:0] cool_inc;
	logic              hit_open;
	logic              hit_close;

	assign pulse_inc = pulse_el_q + TICK_W'(1);
	assign cool_inc = cool_el_q + TICK_W'(1);
	assign hit_open = in_tok_q && (k_q == OPEN_LEN) && m_open_q;
	assign hit_close = in_tok_q && (k_q == CLOSE_LEN) && m_close_q;

	assign stat.eol = (op_q == OP_BYTE)
		&& ((byte_q == CH_CR) || (count_q >= CNT_W'(LINE_CHARS)));
	assign stat.at_end = (idx_q == count_q);
	assign stat.tok_end = in_tok_q && (rd_data_q == CH_SPACE);

	always_comb begin
		count_d = count_q;
		idx_d = idx_q;
		k_d = k_q;
		in_tok_d = in_tok_q;
		m_open_d = m_open_q;
		m_close_d = m_close_q;
		open_d = open_q;
		close_d = close_q;
		run_d = run_q;
		pulse_el_d = pulse_el_q;
		armed_d = armed_q;
		cool_el_d = cool_el_q;
		mem_we = 1'b0;
		res = '0;

		if (cmd.exec) begin
			case (op_q)
				OP_BYTE: begin
					if ((byte_q inside {CH_BS, CH_DEL}) && (count_q != '0)) begin
						count_d = count_q - CNT_W'(1);
					end
					if (byte_q inside {[CH_SPACE : CH_DEL - 8'd1]}) begin
						mem_we = 1'b1;
						count_d = count_q + CNT_W'(1);
					end
				end
				OP_TICK: begin
					if (run_q) begin
						pulse_el_d = pulse_inc;
						if (pulse_inc >= pulse_ticks_q) begin
							run_d = 1'b0;
							pulse_el_d = '0;
							open_d = 1'b0;
							close_d = 1'b0;
							res.report_unlocked = open_q;
							res.report_locked = close_q;
						end
					end
					if (!armed_q) begin
						cool_el_d = cool_inc;
						if (cool_inc >= cool_ticks_q) begin
							armed_d = 1'b1;
							cool_el_d = '0;
						end
					end
				end
				OP_KICK: begin
					if (armed_q) begin
						armed_d = 1'b0;
						cool_el_d = '0;
						res.report_kick = 1'b1;
					end
				end
				default: ;
			endcase
		end

		if (cmd.scan_init) begin
			idx_d = '0;
			k_d = '0;
			in_tok_d = 1'b0;
			m_open_d = 1'b1;
			m_close_d = 1'b1;
		end

		if (cmd.step) begin
			idx_d = idx_q + CNT_W'(1);
			if (rd_data_q != CH_SPACE) begin
				in_tok_d = 1'b1;
				m_open_d = m_open_q && (k_q < OPEN_LEN)
					&& (rd_data_q == word_open_char(k_q[1:0]));
				m_close_d = m_close_q && (k_q < CLOSE_LEN)
					&& (rd_data_q == word_close_char(k_q[2:0]));
				k_d = k_q + CNT_W'(1);
			end
		end

		if (cmd.finish) begin
			count_d = '0;
			if (hit_open) begin
				open_d = 1'b1;
			end
			if (hit_close) begin
				close_d = 1'b1;
			end
			if ((hit_open || hit_close) && !run_q) begin
				run_d = 1'b1;
				pulse_el_d = '0;
			end
		end

		res.open_drive = open_d;
		res.close_drive = close_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[count_q[IDX_W-1:0]] <= byte_q;
		end
		rd_data_q <= line_mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			byte_q <= in_byte;
		end
		idx_q <= idx_d;
		k_q <= k_d;
		in_tok_q <= in_tok_d;
		m_open_q <= m_open_d;
		m_close_q <= m_close_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			open_q <= 1'b0;
			close_q <= 1'b0;
			run_q <= 1'b0;
			pulse_el_q <= '0;
			armed_q <= 1'b1;
			cool_el_q <= '0;
			pulse_ticks_q <= PULSE_TICKS_RST;
			cool_ticks_q <= COOLDOWN_TICKS_RST;
		end else begin
			count_q <= count_d;
			open_q <= open_d;
			close_q <= close_d;
			run_q <= run_d;
			pulse_el_q <= pulse_el_d;
			armed_q <= armed_d;
			cool_el_q <= cool_el_d;
			if (cfg_we && (cfg_index == REG_PULSE_TICKS)) begin
				pulse_ticks_q <= cfg_data;
			end
			if (cfg_we && (cfg_index == REG_COOLDOWN_TICKS)) begin
				cool_ticks_q <= cfg_data;
			end
		end
	end

`ifndef SYNTHESIS
	a_drive_has_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q || close_q) |-> run_q)
		else $error("drive raised without a running pulse timer");
	a_cooldown_only_disarmed: assert property (@(posedge clk) disable iff (!arst_n)
		(cool_el_q != '0) |-> !armed_q)
		else $error("cooldown counting while armed");
	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(LINE_CHARS))
		else $error("character count beyond line length");
	a_idle_timer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!run_q |-> (pulse_el_q == '0))
		else $error("pulse count held while timer idle");
`endif

endmodule
`default_nettype wire

FILE: sv/line_command_lock_controller.sv
// Each accepted transaction is a received byte, a time tick or a kick edge, and gives
// exactly one result transaction. A carriage return, or any byte arriving on a full
// line, ends the line; the stored line is then scanned through its memory read port
// up to the end of the first token. One transaction is processed at a time; a finished
// result waits in a holding register and the output register, so the next transaction
// can be accepted while the consumer stalls. The line store needs no clearing after
// reset. Depends on lcl_pkg, lcl_ctrl and lcl_datapath.
`default_nettype none
module line_command_lock_controller
	import lcl_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [7:0]           s_axis_tdata,  // rx_byte
	input  wire logic [1:0]           s_axis_tuser,  // operation
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// open_drive, close_drive, report_unlocked, report_locked, report_kick, zero pad
	output logic [7:0]                m_axis_tdata,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [TICK_W-1:0]    cfg_data
);

	lcl_cmd_t  cmd;
	lcl_stat_t stat;
	lcl_res_t  res;
	logic      idle;
	logic      in_fire;
	logic      done;
	logic      out_free;
	logic      pend_valid_q;
	lcl_res_t  pend_data_q;
	logic      out_valid_q;
	lcl_res_t  out_data_q;

	assign s_axis_tready = idle && !pend_valid_q;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign done = cmd.exec || cmd.finish;
	assign out_free = !out_valid_q || m_axis_tready;

	lcl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_fire (in_fire),
		.stat    (stat),
		.cmd     (cmd),
		.idle    (idle)
	);

	lcl_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_op     (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.stat      (stat),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				pend_valid_q <= 1'b1;
			end else if (pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= pend_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			pend_data_q <= res;
		end
		if (out_free && pend_valid_q) begin
			out_data_q <= pend_data_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {3'b000, out_data_q};

endmodule
`default_nettype wire

FILE: tb/lcl_lock_checker.sv
// Checker for the line command lock controller: follows the configuration port and both
// stream channels, predicts each result transaction and compares it field by field.
// Depends on lcl_pkg only.
module lcl_lock_checker
	import lcl_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [7:0]           s_axis_tdata,
	input  logic [1:0]           s_axis_tuser,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [7:0]           m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   outstanding,
	output int                   results_checked,
	output int                   unlock_reports,
	output int                   lock_reports,
	output int                   kick_reports
);

	localparam logic [31:0] WORD_OPEN = "open";
	localparam logic [39:0] WORD_CLOSE = "close";

	logic [7:0] line_buf [LINE_CHARS];
	int line_len;
	logic open_lvl, close_lvl, pulse_on, armed;
	logic [TICK_W-1:0] pulse_cnt, cool_cnt, pulse_len, cool_len;

	lcl_res_t results_due [$];
	int fails, checked, unlocks, locks, kicks;

	// The first space-delimited token decides the command; an empty or blank line does nothing.
	function automatic void evaluate_line();
		int tok_lo, tok_hi;
		bit is_open, is_close;
		tok_lo = 0;
		while (tok_lo < line_len && line_buf[tok_lo] == CH_SPACE)
			tok_lo++;
		tok_hi = tok_lo;
		while (tok_hi < line_len && line_buf[tok_hi] != CH_SPACE)
			tok_hi++;
		line_len = 0;
		is_open = (tok_hi - tok_lo == 4);
		is_close = (tok_hi - tok_lo == 5);
		for (int k = 0; k < 5; k++) begin
			if (k < 4 && is_open && line_buf[tok_lo + k] != WORD_OPEN[8 * (3 - k) +: 8])
				is_open = 1'b0;
			if (is_close && line_buf[tok_lo + k] != WORD_CLOSE[8 * (4 - k) +: 8])
				is_close = 1'b0;
		end
		if (is_open)
			open_lvl = 1'b1;
		if (is_close)
			close_lvl = 1'b1;
		if ((is_open || is_close) && !pulse_on) begin
			pulse_on = 1'b1;
			pulse_cnt = '0;
		end
	endfunction

	function automatic lcl_res_t advance_lock(input logic [1:0] op, input logic [7:0] ch);
		lcl_res_t res;
		res = '0;
		case (op)
			OP_BYTE: begin
				if (ch == CH_CR || line_len >= LINE_CHARS) begin
					evaluate_line();
				end else begin
					if ((ch inside {CH_BS, CH_DEL}) && line_len > 0)
						line_len--;
					if (ch inside {[CH_SPACE : CH_DEL - 8'd1]}) begin
						line_buf[line_len] = ch;
						line_len++;
					end
				end
			end
			OP_TICK: begin
				if (pulse_on) begin
					pulse_cnt++;
					if (pulse_cnt >= pulse_len) begin
						pulse_on = 1'b0;
						pulse_cnt = '0;
						res.report_unlocked = open_lvl;
						res.report_locked = close_lvl;
						open_lvl = 1'b0;
						close_lvl = 1'b0;
					end
				end
				if (!armed) begin
					cool_cnt++;
					if (cool_cnt >= cool_len) begin
						armed = 1'b1;
						cool_cnt = '0;
					end
				end
			end
			OP_KICK: begin
				if (armed) begin
					armed = 1'b0;
					cool_cnt = '0;
					res.report_kick = 1'b1;
				end
			end
			default: ;
		endcase
		res.open_drive = open_lvl;
		res.close_drive = close_lvl;
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want_v,
			input logic [7:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fails++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		lcl_res_t got, want;
		if (!arst_n) begin
			line_len = 0;
			open_lvl = 1'b0;
			close_lvl = 1'b0;
			pulse_on = 1'b0;
			pulse_cnt = '0;
			armed = 1'b1;
			cool_cnt = '0;
			pulse_len = PULSE_TICKS_RST;
			cool_len = COOLDOWN_TICKS_RST;
			results_due.delete();
			fails = 0;
			checked = 0;
			unlocks = 0;
			locks = 0;
			kicks = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PULSE_TICKS: pulse_len = cfg_data;
					REG_COOLDOWN_TICKS: cool_len = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = lcl_res_t'(m_axis_tdata[4:0]);
				if (results_due.size() == 0) begin
					$error("result transaction %0h arrived with nothing expected", m_axis_tdata);
					fails++;
				end else begin
					want = results_due.pop_front();
					checked++;
					unlocks += int'(want.report_unlocked);
					locks += int'(want.report_locked);
					kicks += int'(want.report_kick);
					check_field("open_drive", 8'(want.open_drive), 8'(got.open_drive));
					check_field("close_drive", 8'(want.close_drive), 8'(got.close_drive));
					check_field("report_unlocked", 8'(want.report_unlocked),
						8'(got.report_unlocked));
					check_field("report_locked", 8'(want.report_locked),
						8'(got.report_locked));
					check_field("report_kick", 8'(want.report_kick), 8'(got.report_kick));
					check_field("padding", 8'd0, 8'(m_axis_tdata[7:5]));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				results_due.push_back(advance_lock(s_axis_tuser, s_axis_tdata));
		end
		mismatches <= fails;
		outstanding <= results_due.size();
		results_checked <= checked;
		unlock_reports <= unlocks;
		lock_reports <= locks;
		kick_reports <= kicks;
	end

endmodule

FILE: tb/line_command_lock_controller_test.sv
// Top of the line command lock controller testbench: clock, reset, timer settings and
// stimulus, with random idling on both channels, a watchdog and the verdict.
// Depends on lcl_pkg, line_command_lock_controller and lcl_lock_checker.
module line_command_lock_controller_test;
	import lcl_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int PHASES = 9;
	localparam int PHASE_ITEMS = 170;
	localparam int DRAIN_CYCLES = 2 * LINE_CHARS + 10;
	localparam int WATCHDOG_CYCLES = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0] cfg_data = '0;

	int mismatches, outstanding, results_checked, unlock_reports, lock_reports, kick_reports;
	int items_sent = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	bit no_gaps = 1'b0;
	logic [TICK_W-1:0] pulse_now = PULSE_TICKS_RST;

	logic [TICK_W-1:0] pulse_plan [PHASES] = '{32'd1, 32'd5, 32'd0, 32'd12, 32'hFFFF_FFFF,
		32'd3, PULSE_TICKS_RST, 32'd1, 32'd9};
	logic [TICK_W-1:0] cooldown_plan [PHASES] = '{32'd1, 32'd3, 32'd0, 32'd30, 32'hFFFF_FFFF,
		32'd1, COOLDOWN_TICKS_RST, 32'hFFFF_FFFF, 32'd2};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	line_command_lock_controller u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	lcl_lock_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_checked(results_checked),
		.unlock_reports(unlock_reports),
		.lock_reports(lock_reports),
		.kick_reports(kick_reports)
	);

	// Mostly short pauses, now and then a long one.
	function automatic int idle_span();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= idle_span() - 1;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_item(input logic [1:0] op, input logic [7:0] ch);
		int gap;
		gap = (!no_gaps && $urandom_range(0, 2) == 0) ? idle_span() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= ch;
		s_axis_tuser <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic type_text(input string text);
		for (int i = 0; i < text.len(); i++)
			push_item(OP_BYTE, text[i]);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic set_timing(input logic [TICK_W-1:0] pulse, input logic [TICK_W-1:0] cool);
		cfg_we <= 1'b1;
		cfg_index <= REG_PULSE_TICKS;
		cfg_data <= pulse;
		@(posedge clk);
		cfg_index <= REG_COOLDOWN_TICKS;
		cfg_data <= cool;
		@(posedge clk);
		cfg_we <= 1'b0;
		pulse_now = pulse;
	endtask

	// Mostly well-formed command lines and tick runs, with kicks, edits, noise and full lines.
	task automatic run_phase(input int count);
		int stop, pick, edit_at;
		string tok, head;
		stop = items_sent + count;
		while (items_sent < stop) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				case ($urandom_range(0, 9))
					0, 1, 2: tok = "open";
					3, 4, 5: tok = "close";
					6: tok = "opn";
					7: tok = "closed";
					8: tok = "OPEN";
					default: tok = "clos";
				endcase
				edit_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, tok.len() - 1) : -1;
				if ($urandom_range(0, 2) == 0)
					push_item(OP_BYTE, CH_CR);
				repeat ($urandom_range(0, 2)) push_item(OP_BYTE, CH_SPACE);
				for (int i = 0; i < tok.len(); i++) begin
					if (i == edit_at) begin
						push_item(OP_BYTE, 8'($urandom_range(33, 126)));
						push_item(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
					end
					push_item(OP_BYTE, tok[i]);
				end
				if ($urandom_range(0, 2) == 0) begin
					push_item(OP_BYTE, CH_SPACE);
					repeat ($urandom_range(1, 5)) push_item(OP_BYTE, 8'($urandom_range(32, 126)));
				end
				push_item(OP_BYTE, CH_CR);
			end else if (pick < 65) begin
				repeat ((pulse_now <= 40) ? $urandom_range(1, pulse_now + 2) : $urandom_range(1, 6))
					push_item(OP_TICK, 8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 3)) push_item(OP_KICK, 8'($urandom_range(0, 255)));
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 6))
					push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (pick < 99) begin
				repeat ($urandom_range(0, 4)) push_item(OP_BYTE, 8'($urandom_range(32, 126)));
				repeat ($urandom_range(1, 6))
					push_item(OP_BYTE, $urandom_range(0, 1) ? CH_BS : CH_DEL);
				if ($urandom_range(0, 3) != 0)
					push_item(OP_BYTE, CH_CR);
			end else begin
				case ($urandom_range(0, 2))
					0: head = "open ";
					1: head = "close";
					default: head = "";
				endcase
				push_item(OP_BYTE, CH_CR);
				type_text(head);
				repeat (LINE_CHARS - head.len()) push_item(OP_BYTE, 8'($urandom_range(32, 126)));
				push_item(OP_BYTE, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_timing(32'd2, 32'd1);

		push_item(OP_BYTE, CH_BS);
		push_item(OP_BYTE, CH_DEL);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_SPARE, 8'hAA);
		push_item(OP_BYTE, CH_CR);
		push_item(OP_BYTE, CH_SPACE);
		push_item(OP_BYTE, CH_CR);
		type_text("open");
		push_item(OP_BYTE, CH_CR);
		type_text("close");
		push_item(OP_BYTE, CH_CR);
		push_item(OP_TICK, 8'h55);
		push_item(OP_KICK, 8'h55);
		push_item(OP_KICK, 8'h00);
		push_item(OP_TICK, 8'hFF);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			set_timing(pulse_plan[p], cooldown_plan[p]);
			no_gaps = (p == 3);
			run_phase(PHASE_ITEMS);
			settle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d transactions under %0d timer settings; %0d results compared.",
			items_sent, PHASES + 1, results_checked);
		$display("Reports covered: %0d unlock, %0d lock, %0d kick.",
			unlock_reports, lock_reports, kick_reports);
		if (mismatches == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
